[sv/midpoint_ellipse_rasterizer_top_macros.svh]
// Assertion macros for the ellipse rasterizer checker.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define MER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// Shared codes for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    // input word kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // result primitive kinds
    localparam logic PRIM_PLOT = 1'b0;
    localparam logic PRIM_SPAN = 1'b1;

endpackage

[sv/mer_ifs.sv]
// ----------------------------------------------------------------------------
// mer_in_if / mer_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface mer_in_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] corner_ax;
    logic signed [COORD_BITS-1:0] corner_ay;
    logic signed [COORD_BITS-1:0] corner_bx;
    logic signed [COORD_BITS-1:0] corner_by;
    logic                         solid;

    modport source (output valid, kind, corner_ax, corner_ay, corner_bx, corner_by, solid,
                    input ready);
    modport sink   (input valid, kind, corner_ax, corner_ay, corner_bx, corner_by, solid,
                    output ready);
endinterface

interface mer_out_if #(parameter int COORD_BITS = 12);
    logic                       valid;
    logic                       ready;
    logic                       prim_kind;
    logic signed [COORD_BITS:0] x_left;
    logic signed [COORD_BITS:0] x_right;
    logic signed [COORD_BITS:0] row_y;
    logic                       last;
    logic                       finished;

    modport source (output valid, prim_kind, x_left, x_right, row_y, last, finished,
                    input ready);
    modport sink   (input valid, prim_kind, x_left, x_right, row_y, last, finished,
                    output ready);
endinterface

[sv/midpoint_ellipse_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse rasterizer: box in, plot points or spans out.
// ----------------------------------------------------------------------------
// A start word is taken from the queue, then three chained products through
// one shared multiplier set up the ellipse; when it begins in the second
// region, the multiplier then recomputes the decision term. An advance word
// leaves the queue, emits one result word per cycle (one to four, held while
// the result register is stalled), then updates the iteration terms, and on
// the iteration that crosses into the second region the multiplier recomputes
// the decision term. An advance with no active ellipse is dropped.
// A two-word queue sits between the input and the iteration engine, and the
// result word is registered.
module midpoint_ellipse_rasterizer_top #(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mer_in_if.sink    i_in,
    mer_out_if.source o_out
);
    localparam int CMD_W = 4 * COORD_BITS + 2;

    logic             push, room, q_valid, pop;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    mer_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_in   (i_in),
        .o_push (push),
        .o_cmd  (cmd_in),
        .i_room (room)
    );

    mer_queue #(.WIDTH(CMD_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_room  (room),
        .o_valid (q_valid),
        .o_data  (cmd_out),
        .i_pop   (pop)
    );

    mer_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

[sv/mer_front.sv]
// ----------------------------------------------------------------------------
// mer_front
// Accepts input words and turns a box into radii and centre.
// ----------------------------------------------------------------------------
module mer_front #(
    parameter  int COORD_BITS = 12,
    localparam int CMD_W      = 4 * COORD_BITS + 2
) (
    mer_in_if.sink            i_in,
    output logic              o_push,
    output logic [CMD_W-1:0]  o_cmd,
    input  logic              i_room
);
    import mer_pkg::*;

    localparam int C = COORD_BITS;

    logic signed [C:0]   dx, dy, sx, sy, hx, hy;
    logic        [C:0]   adx, ady;
    logic        [C-1:0] rx, ry;
    logic                kind;

    assign i_in.ready = i_room;
    assign o_push     = i_in.valid && i_room;

    // box to radius and centre, halves truncate toward zero
    always_comb begin
        dx  = (C+1)'(i_in.corner_ax) - (C+1)'(i_in.corner_bx);
        dy  = (C+1)'(i_in.corner_ay) - (C+1)'(i_in.corner_by);
        adx = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
        ady = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
        rx  = adx[C:1];
        ry  = ady[C:1];
        sx  = (C+1)'(i_in.corner_ax) + (C+1)'(i_in.corner_bx);
        sy  = (C+1)'(i_in.corner_ay) + (C+1)'(i_in.corner_by);
        hx  = (sx + (C+1)'(sx[C])) >>> 1;
        hy  = (sy + (C+1)'(sy[C])) >>> 1;
        kind = (i_in.kind == KIND_ADVANCE) ? KIND_ADVANCE : KIND_START;
    end

    assign o_cmd = {kind, i_in.solid, rx, ry, hx[C-1:0], hy[C-1:0]};

endmodule

[sv/mer_queue.sv]
// ----------------------------------------------------------------------------
// mer_queue
// Two-entry word queue between the front and the back.
// ----------------------------------------------------------------------------
module mer_queue #(
    parameter int WIDTH = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_room,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp, n_wp, n_rp;
    logic [1:0]       r_cnt, n_cnt;

    assign o_room  = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[sv/mer_back.sv]
// ----------------------------------------------------------------------------
// mer_back
// Runs the ellipse iterations: setup multiplies, point emission, term update.
// ----------------------------------------------------------------------------
module mer_back #(
    parameter  int COORD_BITS = 12,
    localparam int CMD_W      = 4 * COORD_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  logic [CMD_W-1:0]  i_cmd,
    output logic              o_pop,
    mer_out_if.source         o_out
);
    import mer_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SQW = 2 * C;
    localparam int MW  = 2 * C + 2;
    localparam int DW  = 2 * MW;
    localparam int SW  = 3 * C + 2;
    localparam int XW  = C + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ST0  = 4'd1;
    localparam logic [3:0] S_ST1  = 4'd2;
    localparam logic [3:0] S_ST2  = 4'd3;
    localparam logic [3:0] S_ST3  = 4'd4;
    localparam logic [3:0] S_EMIT = 4'd5;
    localparam logic [3:0] S_UPD1 = 4'd6;
    localparam logic [3:0] S_UPD2 = 4'd7;
    localparam logic [3:0] S_E0   = 4'd8;
    localparam logic [3:0] S_E1   = 4'd9;
    localparam logic [3:0] S_E2   = 4'd10;
    localparam logic [3:0] S_E3   = 4'd11;
    localparam logic [3:0] S_E4   = 4'd12;
    localparam logic [3:0] S_E5   = 4'd13;

    logic [3:0]             r_state;
    logic                   r_busy, r_reg2, r_fill, r_br;
    logic [1:0]             r_k;
    logic [C-1:0]           r_rx, r_ry;
    logic signed [C-1:0]    r_cx, r_cy;
    logic signed [XW-1:0]   r_x, r_y;
    logic [SQW-1:0]         r_rx2, r_ry2;
    logic signed [SW-1:0]   r_sdx, r_sdy;
    logic signed [DW-1:0]   r_dec, r_prod;
    logic signed [MW-1:0]   r_acc, r_tmp;
    logic signed [MW-1:0]   n_ma, n_mb;

    logic                   r_out_valid, r_out_kind, r_out_last, r_out_fin;
    logic signed [XW-1:0]   r_out_xl, r_out_xr, r_out_y;

    logic                   out_free;
    logic [3:0]             en, above;
    logic [1:0]             sel;
    logic                   is_last, fin;
    logic signed [C+1:0]    cx_p, cx_m, cy_p, cy_m;
    logic signed [MW-1:0]   rx2_m, ry2_m, a_m, b_m;
    logic signed [DW-1:0]   rx2_d, ry2_d, sdx_d, sdy_d;
    logic signed [SW-1:0]   rx2_s, ry2_s;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;

    // extended copies of stored terms
    always_comb begin
        rx2_m = MW'(r_rx2);
        ry2_m = MW'(r_ry2);
        rx2_d = DW'(r_rx2);
        ry2_d = DW'(r_ry2);
        rx2_s = SW'(r_rx2);
        ry2_s = SW'(r_ry2);
        sdx_d = DW'(r_sdx);
        sdy_d = DW'(r_sdy);
        a_m   = MW'(r_x) + MW'(r_x) + MW'(1);
        b_m   = MW'(r_y) - MW'(1);
    end

    // symmetric point selection
    always_comb begin
        en[0] = 1'b1;
        en[1] = r_fill ? (r_y != '0) : (r_x != '0);
        en[2] = !r_fill && (r_y != '0);
        en[3] = !r_fill && (r_y != '0) && (r_x != '0);
        sel   = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (en[i] && (2'(i) >= r_k)) begin
                sel = 2'(i);
            end
        end
        above   = en & 4'(4'b1110 << sel);
        is_last = (above == 4'd0);
        fin     = r_reg2 && (r_y == '0);
        cx_p    = (C+2)'(r_cx) + (C+2)'(r_x);
        cx_m    = (C+2)'(r_cx) - (C+2)'(r_x);
        cy_p    = (C+2)'(r_cy) + (C+2)'(r_y);
        cy_m    = (C+2)'(r_cy) - (C+2)'(r_y);
    end

    // shared multiplier operands
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            S_ST0:   begin n_ma = MW'(r_rx); n_mb = MW'(r_rx); end
            S_ST1:   begin n_ma = MW'(r_ry); n_mb = MW'(r_ry); end
            S_ST2:   begin n_ma = rx2_m;     n_mb = MW'(r_ry); end
            S_E0:    begin n_ma = a_m;       n_mb = a_m;       end
            S_E1:    begin n_ma = b_m;       n_mb = b_m;       end
            S_E2:    begin n_ma = ry2_m;     n_mb = r_acc;     end
            S_E3:    begin n_ma = rx2_m;     n_mb = ry2_m;     end
            S_E4:    begin n_ma = rx2_m;     n_mb = r_tmp;     end
            default: begin n_ma = '0;        n_mb = '0;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
    end

    // sequencer and iteration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_reg2      <= 1'b0;
            r_fill      <= 1'b0;
            r_br        <= 1'b0;
            r_k         <= 2'd0;
            r_rx        <= '0;
            r_ry        <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_rx2       <= '0;
            r_ry2       <= '0;
            r_sdx       <= '0;
            r_sdy       <= '0;
            r_dec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd[CMD_W-1] == KIND_START) begin
                            r_fill  <= i_cmd[CMD_W-2];
                            r_rx    <= i_cmd[4*C-1:3*C];
                            r_ry    <= i_cmd[3*C-1:2*C];
                            r_cx    <= i_cmd[2*C-1:C];
                            r_cy    <= i_cmd[C-1:0];
                            r_state <= S_ST0;
                        end else if (r_busy) begin
                            r_k     <= 2'd0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_ST0: r_state <= S_ST1;
                S_ST1: begin
                    r_rx2   <= r_prod[SQW-1:0];
                    r_state <= S_ST2;
                end
                S_ST2: begin
                    r_ry2   <= r_prod[SQW-1:0];
                    r_state <= S_ST3;
                end
                S_ST3: begin
                    r_x    <= '0;
                    r_y    <= XW'(r_ry);
                    r_sdx  <= '0;
                    r_sdy  <= SW'(r_prod <<< 1);
                    r_dec  <= (ry2_d <<< 2) - (r_prod <<< 2) + rx2_d;
                    r_reg2 <= 1'b0;
                    r_busy <= 1'b1;
                    r_state <= (r_prod > 0) ? S_IDLE : S_E0;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_fill ? PRIM_SPAN : PRIM_PLOT;
                        r_out_last  <= is_last;
                        r_out_fin   <= fin;
                        if (r_fill) begin
                            r_out_xl <= cx_m[XW-1:0];
                            r_out_xr <= cx_p[XW-1:0];
                            r_out_y  <= sel[0] ? cy_m[XW-1:0] : cy_p[XW-1:0];
                        end else begin
                            r_out_xl <= sel[0] ? cx_m[XW-1:0] : cx_p[XW-1:0];
                            r_out_xr <= sel[0] ? cx_m[XW-1:0] : cx_p[XW-1:0];
                            r_out_y  <= sel[1] ? cy_m[XW-1:0] : cy_p[XW-1:0];
                        end
                        if (is_last) begin
                            r_state <= S_UPD1;
                        end else begin
                            r_k <= sel + 2'd1;
                        end
                    end
                end
                S_UPD1: begin
                    if (!r_reg2) begin
                        r_x   <= r_x + XW'(1);
                        r_sdx <= r_sdx + (ry2_s <<< 1);
                        r_br  <= r_dec < 0;
                        if (!(r_dec < 0)) begin
                            r_y   <= r_y - XW'(1);
                            r_sdy <= r_sdy - (rx2_s <<< 1);
                        end
                    end else begin
                        r_y   <= r_y - XW'(1);
                        r_sdy <= r_sdy - (rx2_s <<< 1);
                        r_br  <= r_dec > 0;
                        if (!(r_dec > 0)) begin
                            r_x   <= r_x + XW'(1);
                            r_sdx <= r_sdx + (ry2_s <<< 1);
                        end
                    end
                    r_state <= S_UPD2;
                end
                S_UPD2: begin
                    if (!r_reg2) begin
                        r_dec <= r_br ? r_dec + (sdx_d <<< 2) + (ry2_d <<< 2)
                                      : r_dec + (sdx_d <<< 2) - (sdy_d <<< 2) + (ry2_d <<< 2);
                        r_state <= (r_sdx < r_sdy) ? S_IDLE : S_E0;
                    end else begin
                        r_dec <= r_br ? r_dec + (rx2_d <<< 2) - (sdy_d <<< 2)
                                      : r_dec + (sdx_d <<< 2) - (sdy_d <<< 2) + (rx2_d <<< 2);
                        if (r_y < 0) begin
                            r_busy <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_E0: r_state <= S_E1;
                S_E1: begin
                    r_acc   <= r_prod[MW-1:0];
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_tmp   <= r_prod[MW-1:0];
                    r_state <= S_E3;
                end
                S_E3: begin
                    r_dec   <= r_prod;
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_dec   <= r_dec - (r_prod <<< 2);
                    r_state <= S_E5;
                end
                S_E5: begin
                    r_dec   <= r_dec + (r_prod <<< 2);
                    r_reg2  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.prim_kind = r_out_kind;
    assign o_out.x_left    = r_out_xl;
    assign o_out.x_right   = r_out_xr;
    assign o_out.row_y     = r_out_y;
    assign o_out.last      = r_out_last;
    assign o_out.finished  = r_out_fin;

endmodule

[sv/mer_checker.sv]
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks on the rasterizer result channel.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_rasterizer_top_macros.svh"

module mer_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic                       i_prim_kind,
    input logic signed [COORD_BITS:0] i_x_left,
    input logic signed [COORD_BITS:0] i_x_right,
    input logic signed [COORD_BITS:0] i_row_y
);
    import mer_pkg::*;

    // a stalled word stays
    `MER_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid, "result word dropped")
    `MER_ASSERT_NEXT(a_stable, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_x_left) && $stable(i_row_y), "stalled word changed")

    // plot words are one pixel, spans run left to right
    `MER_ASSERT_NOW(a_plot, i_clk, i_rst_n, i_valid && i_prim_kind == PRIM_PLOT, i_x_left == i_x_right, "plot ends differ")
    `MER_ASSERT_NOW(a_span, i_clk, i_rst_n, i_valid && i_prim_kind == PRIM_SPAN, i_x_left <= i_x_right, "span reversed")

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_prim_kind (o_out.prim_kind),
    .i_x_left    (o_out.x_left),
    .i_x_right   (o_out.x_right),
    .i_row_y     (o_out.row_y)
);

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the midpoint ellipse rasterizer. Start and advance words go
// in through a queue-fed driver with random gaps. Each accepted word is run
// through an in-bench model of the ellipse walk. The monitor compares every
// plot or span word, field by field, with the oldest predicted one, under
// random back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import mer_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int LIMIT      = 600000;

    typedef struct {
        logic                         kind;
        logic signed [COORD_BITS-1:0] ax, ay, bx, by;
        logic                         solid;
        bit                           drain;     // hold until all results are in
    } box_word_t;

    typedef struct {
        logic                       prim;
        logic signed [COORD_BITS:0] xl, xr, yy;
        logic                       last, fin;
    } pixel_word_t;

    logic i_clk;
    logic i_rst_n;

    mer_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
    mer_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

    midpoint_ellipse_rasterizer_top #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // clock and counters
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    box_word_t   pending_q[$];
    pixel_word_t pixel_q[$];
    box_word_t   cur_word;
    int          errors, cycles;
    int          n_starts, n_advances, n_pixels, n_done;

    // ellipse walker state
    longint rad_x, rad_y, ctr_x, ctr_y, walk_x, walk_y;
    longint slope_x, slope_y, decision;
    bit     region_two, filled, active;

    function automatic void push_pixel(logic prim, longint xl, longint xr, longint yy);
        pixel_word_t p;
        p.prim = prim;
        p.xl   = xl[COORD_BITS:0];
        p.xr   = xr[COORD_BITS:0];
        p.yy   = yy[COORD_BITS:0];
        p.last = 1'b0;
        p.fin  = 1'b0;
        pixel_q.push_back(p);
    endfunction

    function automatic void switch_region();
        longint a, b;
        a = 2 * walk_x + 1;
        b = walk_y - 1;
        decision = rad_y * rad_y * a * a - 4 * rad_x * rad_x * rad_y * rad_y
                   + 4 * rad_x * rad_x * b * b;
        region_two = 1'b1;
    endfunction

    function automatic void walk_ellipse(box_word_t w);
        longint ddx, ddy, rx2, ry2;
        int     base, n;
        bit     fin;
        if (w.kind == KIND_START) begin
            n_starts++;
            ddx = longint'(w.ax) - longint'(w.bx);
            ddy = longint'(w.ay) - longint'(w.by);
            rad_x = (ddx < 0 ? -ddx : ddx) / 2;
            rad_y = (ddy < 0 ? -ddy : ddy) / 2;
            ctr_x = (longint'(w.ax) + longint'(w.bx)) / 2;
            ctr_y = (longint'(w.ay) + longint'(w.by)) / 2;
            filled = w.solid;
            walk_x = 0;
            walk_y = rad_y;
            rx2 = rad_x * rad_x;
            ry2 = rad_y * rad_y;
            slope_x = 0;
            slope_y = 2 * rx2 * rad_y;
            decision = 4 * ry2 - 4 * rx2 * rad_y + rx2;
            region_two = 1'b0;
            active = 1'b1;
            if (!(slope_x < slope_y)) switch_region();
            return;
        end
        n_advances++;
        if (!active) return;
        rx2  = rad_x * rad_x;
        ry2  = rad_y * rad_y;
        base = pixel_q.size();
        fin  = 1'b0;
        // symmetric points or spans for this step
        if (filled) begin
            push_pixel(PRIM_SPAN, ctr_x - walk_x, ctr_x + walk_x, ctr_y + walk_y);
            if (walk_y != 0)
                push_pixel(PRIM_SPAN, ctr_x - walk_x, ctr_x + walk_x, ctr_y - walk_y);
        end else begin
            push_pixel(PRIM_PLOT, ctr_x + walk_x, ctr_x + walk_x, ctr_y + walk_y);
            if (walk_x != 0)
                push_pixel(PRIM_PLOT, ctr_x - walk_x, ctr_x - walk_x, ctr_y + walk_y);
            if (walk_y != 0) begin
                push_pixel(PRIM_PLOT, ctr_x + walk_x, ctr_x + walk_x, ctr_y - walk_y);
                if (walk_x != 0)
                    push_pixel(PRIM_PLOT, ctr_x - walk_x, ctr_x - walk_x, ctr_y - walk_y);
            end
        end
        // decision update
        if (!region_two) begin
            walk_x++;
            slope_x += 2 * ry2;
            if (decision < 0) begin
                decision += 4 * slope_x + 4 * ry2;
            end else begin
                walk_y--;
                slope_y -= 2 * rx2;
                decision += 4 * slope_x - 4 * slope_y + 4 * ry2;
            end
            if (!(slope_x < slope_y)) switch_region();
        end else begin
            walk_y--;
            slope_y -= 2 * rx2;
            if (decision > 0) begin
                decision += 4 * rx2 - 4 * slope_y;
            end else begin
                walk_x++;
                slope_x += 2 * ry2;
                decision += 4 * slope_x - 4 * slope_y + 4 * rx2;
            end
            if (walk_y < 0) begin
                active = 1'b0;
                fin = 1'b1;
                n_done++;
            end
        end
        n = pixel_q.size();
        for (int k = base; k < n; k++) begin
            pixel_q[k].last = (k == n - 1);
            pixel_q[k].fin  = fin;
        end
    endfunction

    // word builders
    function automatic void add_start(int ax, int ay, int bx, int by, bit solid);
        box_word_t w;
        w.kind  = KIND_START;
        w.ax    = ax[COORD_BITS-1:0];
        w.ay    = ay[COORD_BITS-1:0];
        w.bx    = bx[COORD_BITS-1:0];
        w.by    = by[COORD_BITS-1:0];
        w.solid = solid;
        w.drain = 1'b0;
        pending_q.push_back(w);
    endfunction

    function automatic void add_advances(int n);
        box_word_t w;
        for (int i = 0; i < n; i++) begin
            w.kind  = KIND_ADVANCE;
            w.ax    = COORD_BITS'($urandom);
            w.ay    = COORD_BITS'($urandom);
            w.bx    = COORD_BITS'($urandom);
            w.by    = COORD_BITS'($urandom);
            w.solid = 1'($urandom);
            w.drain = 1'b0;
            pending_q.push_back(w);
        end
    endfunction

    // stimulus
    initial begin
        int counted, ax, ay, bx, by, rx, ry, n;
        i_rst_n = 1'b0;
        add_advances(2);                                  // advance while idle
        add_start(0, 0, 0, 0, 1'b0);                      // zero box, region two at once
        add_advances(2);
        add_start(-2048, -2048, 2047, 2047, 1'b0);        // extreme corners
        add_advances(3);
        add_start(2047, 2047, -2048, -2048, 1'b1);        // replaces active ellipse
        add_advances(2);
        add_start(-3, 5, 0, -8, 1'b0);                    // centre halved toward zero
        add_advances(7);
        add_start(10, 4, 0, 4, 1'b1);                     // flat ellipse
        add_advances(4);
        counted = pending_q.size();
        while (counted < 200) begin
            if ($urandom_range(0, 9) == 0) begin
                ax = $urandom_range(0, 4095) - 2048;
                ay = $urandom_range(0, 4095) - 2048;
                bx = $urandom_range(0, 4095) - 2048;
                by = $urandom_range(0, 4095) - 2048;
                n  = $urandom_range(0, 6);
            end else begin
                ax = $urandom_range(0, 4040) - 2020;
                ay = $urandom_range(0, 4040) - 2020;
                bx = ax + $urandom_range(0, 24) - 12;
                by = ay + $urandom_range(0, 24) - 12;
                rx = (ax > bx ? ax - bx : bx - ax) / 2;
                ry = (ay > by ? ay - by : by - ay) / 2;
                n  = rx + ry + 1;
                if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);   // cut short
                else n += $urandom_range(0, 2);                            // a few idle
            end
            add_start(ax, ay, bx, by, 1'($urandom));
            add_advances(n);
            if (counted < 110 && counted + n + 1 >= 110) pending_q[$].drain = 1'b1;
            counted += n + 1;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // input driver
    int in_gap, out_gap;
    bit in_burst, out_burst, in_acc;

    always @(posedge i_clk) begin
        in_acc <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) walk_ellipse(cur_word);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.kind      <= KIND_ADVANCE;
            in_ch.corner_ax <= '0;
            in_ch.corner_ay <= '0;
            in_ch.corner_bx <= '0;
            in_ch.corner_by <= '0;
            in_ch.solid     <= 1'b0;
            in_gap          <= 0;
            in_burst        <= 1'b0;
        end else if (!in_ch.valid || in_acc) begin
            if (in_gap > 0) begin
                in_ch.valid <= 1'b0;
                in_gap      <= in_gap - 1;
            end else if (pending_q.size() == 0
                         || (pending_q[0].drain && pixel_q.size() != 0)) begin
                in_ch.valid <= 1'b0;
            end else begin
                cur_word = pending_q.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.kind      <= cur_word.kind;
                in_ch.corner_ax <= cur_word.ax;
                in_ch.corner_ay <= cur_word.ay;
                in_ch.corner_bx <= cur_word.bx;
                in_ch.corner_by <= cur_word.by;
                in_ch.solid     <= cur_word.solid;
                if ($urandom_range(0, 19) == 0) in_burst <= !in_burst;
                in_gap <= in_burst ? 0 : $urandom_range(0, 17);
            end
        end
    end

    // result sink with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
            out_burst    <= 1'b0;
        end else if (out_gap > 0) begin
            out_ch.ready <= 1'b0;
            out_gap      <= out_gap - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (out_ch.ready && out_ch.valid) begin
                if ($urandom_range(0, 19) == 0) out_burst <= !out_burst;
                out_gap <= out_burst ? 0 : $urandom_range(0, 17);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        pixel_word_t e;
        cycles++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_pixels++;
            if (pixel_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: prim=%0d x=%0d..%0d y=%0d",
                             out_ch.prim_kind, out_ch.x_left, out_ch.x_right, out_ch.row_y);
            end else begin
                e = pixel_q.pop_front();
                if (out_ch.prim_kind !== e.prim || out_ch.x_left !== e.xl
                        || out_ch.x_right !== e.xr || out_ch.row_y !== e.yy
                        || out_ch.last !== e.last || out_ch.finished !== e.fin) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp prim=%0d x=%0d..%0d y=%0d last=%0d fin=%0d,",
                                  " got prim=%0d x=%0d..%0d y=%0d last=%0d fin=%0d"},
                                 e.prim, e.xl, e.xr, e.yy, e.last, e.fin,
                                 out_ch.prim_kind, out_ch.x_left, out_ch.x_right,
                                 out_ch.row_y, out_ch.last, out_ch.finished);
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // end of run
    initial begin
        @(posedge i_rst_n);
        wait (pending_q.size() == 0 && !in_ch.valid && pixel_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (pixel_q.size() != 0) errors += pixel_q.size();
        $display("ran %0d starts and %0d advances, %0d ellipses walked to the end",
                 n_starts, n_advances, n_done);
        $display("checked %0d plot/span words, %0d errors", n_pixels, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
